// ===== rtl/dlle_pkg.sv =====
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared types, constants and helpers of the doubly linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

  localparam int NODE_COUNT = 32;
  localparam int IDX_W      = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int LNK_W      = $clog2(NODE_COUNT + 1);
  localparam int CNT_W      = LNK_W;
  localparam int DATA_W     = 32;
  localparam int FIELD_W    = 6;
  localparam int WIDE_W     = CNT_W + FIELD_W;

  localparam logic [LNK_W-1:0] NIL_LINK  = LNK_W'(NODE_COUNT);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NODE_COUNT);

  typedef enum logic [2:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_END    = 3'd1,
    CMD_INS_AFTER  = 3'd2,
    CMD_INS_BEFORE = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_SEARCH     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_NEW,
    S_FIX
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic signed [31:0] item_value;
    logic signed [31:0] anchor_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [5:0] node_total;
  } out_item_t;

  typedef struct packed {
    logic             set_en;
    logic             clr_en;
    logic [IDX_W-1:0] idx;
  } alloc_ctl_t;

  function automatic logic [FIELD_W-1:0] fit_field(input logic [CNT_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/doubly_linked_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_core
// Ordered list of signed 32-bit values kept in a linked node pool.
// ----------------------------------------------------------------------------
// A command transfer happens on a clock edge with start high and busy low;
// in_data carries the command, the item value and the anchor value. Every
// command produces exactly one result on out_data, marked by out_valid for
// a single cycle. The receiver cannot stall, so the result is taken at the
// end of that cycle.
// Insert front and insert end pass the node write and link fix states
// before the result, or end at once when the pool is full. Insert after,
// insert before, delete and search walk the list from the head one node per
// cycle through a single payload compare; search ends at the match, delete
// adds the link fix state, insert after and before add the node write and
// link fix states unless the pool is full, a miss ends at the list's end
// and an unknown command ends at once. The walk rate is set by the
// registered read of the link memories feeding the next read address. busy
// is high from the transfer until the result is shown and stays low for a
// command that ends at once; a new command can be transferred in the cycle
// its predecessor's result is shown. Reset empties the list at once.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dlle_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output dlle_pkg::out_item_t  out_data
);
  import dlle_pkg::*;

  state_t state_r, state_nxt;

  logic [LNK_W-1:0]  head_r, head_nxt;
  logic [LNK_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [LNK_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [LNK_W-1:0]  at_r, at_nxt;
  logic [LNK_W-1:0]  nb_r, nb_nxt;
  logic [LNK_W-1:0]  nf_r, nf_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              fin;
  logic [1:0]        fin_status;
  logic [CNT_W-1:0]  fin_pos;

  logic [IDX_W-1:0]  free_idx;
  alloc_ctl_t        alloc_ctl;

  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] pay_q;
  logic [LNK_W-1:0]  fwd_q, bwd_q;
  logic              pay_we, fwd_we, bwd_we;
  logic [IDX_W-1:0]  pay_wa, fwd_wa, bwd_wa;
  logic [LNK_W-1:0]  fwd_wd, bwd_wd;

  logic              accept;
  logic              hit;
  logic              full;
  logic              head_null;
  logic              fwd_null;
  logic [LNK_W-1:0]  slot_lnk;

  assign accept    = start && (state_r == S_IDLE);
  assign hit       = (pay_q == key_r);
  assign full      = (len_r == FULL_CNT);
  assign head_null = (head_r == NIL_LINK);
  assign fwd_null  = (fwd_q == NIL_LINK);
  assign slot_lnk  = LNK_W'(slot_r);
  assign rd_addr   = (state_r == S_IDLE) ? head_r[IDX_W-1:0] : fwd_q[IDX_W-1:0];

  dlle_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_wa),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (pay_q)
  );

  dlle_ram #(.WIDTH(LNK_W), .DEPTH(NODE_COUNT)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_wa),
    .wdata (fwd_wd),
    .raddr (rd_addr),
    .rdata (fwd_q)
  );

  dlle_ram #(.WIDTH(LNK_W), .DEPTH(NODE_COUNT)) u_bwd_ram (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_wa),
    .wdata (bwd_wd),
    .raddr (rd_addr),
    .rdata (bwd_q)
  );

  dlle_alloc u_alloc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (alloc_ctl),
    .free_idx (free_idx)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          priority case (in_data.command)
            CMD_INS_FRONT, CMD_INS_END: begin
              state_nxt = full ? S_IDLE : S_NEW;
            end
            CMD_INS_AFTER, CMD_INS_BEFORE, CMD_DELETE, CMD_SEARCH: begin
              state_nxt = head_null ? S_IDLE : S_WALK;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (hit) begin
          priority case (cmd_r)
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              state_nxt = full ? S_IDLE : S_NEW;
            end
            CMD_DELETE: begin
              state_nxt = S_FIX;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end else if (fwd_null) begin
          state_nxt = S_IDLE;
        end
      end
      S_NEW: begin
        state_nxt = S_FIX;
      end
      S_FIX: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    len_nxt    = len_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    key_nxt    = key_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    at_nxt     = at_r;
    nb_nxt     = nb_r;
    nf_nxt     = nf_r;
    slot_nxt   = slot_r;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_pos    = '0;
    pay_we     = 1'b0;
    pay_wa     = slot_r;
    fwd_we     = 1'b0;
    fwd_wa     = slot_r;
    fwd_wd     = NIL_LINK;
    bwd_we     = 1'b0;
    bwd_wa     = slot_r;
    bwd_wd     = NIL_LINK;
    alloc_ctl  = '{set_en: 1'b0, clr_en: 1'b0, idx: slot_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_data.command;
          val_nxt  = in_data.item_value;
          key_nxt  = ((in_data.command == CMD_INS_AFTER) ||
                      (in_data.command == CMD_INS_BEFORE)) ?
                     in_data.anchor_value : in_data.item_value;
          cur_nxt  = head_r;
          pos_nxt  = CNT_W'(1);
          slot_nxt = free_idx;
          priority case (in_data.command)
            CMD_INS_FRONT, CMD_INS_END: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end
            end
            CMD_INS_AFTER, CMD_INS_BEFORE, CMD_DELETE, CMD_SEARCH: begin
              if (head_null) begin
                fin        = 1'b1;
                fin_status = STAT_MISSING;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if (hit) begin
          at_nxt   = cur_r;
          nb_nxt   = bwd_q;
          nf_nxt   = fwd_q;
          slot_nxt = free_idx;
          if (cmd_r == CMD_SEARCH) begin
            fin     = 1'b1;
            fin_pos = pos_r;
          end else if ((cmd_r != CMD_DELETE) && full) begin
            fin        = 1'b1;
            fin_status = STAT_FULL;
          end
        end else if (fwd_null) begin
          fin        = 1'b1;
          fin_status = STAT_MISSING;
        end else begin
          cur_nxt = fwd_q;
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      S_NEW: begin
        pay_we = 1'b1;
        fwd_we = 1'b1;
        bwd_we = 1'b1;
        priority case (cmd_r)
          CMD_INS_FRONT: begin
            fwd_wd = head_r;
            bwd_wd = NIL_LINK;
          end
          CMD_INS_END: begin
            fwd_wd = NIL_LINK;
            bwd_wd = tail_r;
          end
          CMD_INS_AFTER: begin
            fwd_wd = nf_r;
            bwd_wd = at_r;
          end
          default: begin
            fwd_wd = at_r;
            bwd_wd = nb_r;
          end
        endcase
      end
      S_FIX: begin
        fin = 1'b1;
        if (cmd_r == CMD_DELETE) begin
          fwd_we    = (nb_r != NIL_LINK);
          fwd_wa    = nb_r[IDX_W-1:0];
          fwd_wd    = nf_r;
          bwd_we    = (nf_r != NIL_LINK);
          bwd_wa    = nf_r[IDX_W-1:0];
          bwd_wd    = nb_r;
          if (nb_r == NIL_LINK) begin
            head_nxt = nf_r;
          end
          if (nf_r == NIL_LINK) begin
            tail_nxt = nb_r;
          end
          len_nxt   = len_r - CNT_W'(1);
          alloc_ctl = '{set_en: 1'b0, clr_en: 1'b1, idx: at_r[IDX_W-1:0]};
        end else begin
          len_nxt   = len_r + CNT_W'(1);
          alloc_ctl = '{set_en: 1'b1, clr_en: 1'b0, idx: slot_r};
          fwd_wd    = slot_lnk;
          bwd_wd    = slot_lnk;
          priority case (cmd_r)
            CMD_INS_FRONT: begin
              bwd_we   = !head_null;
              bwd_wa   = head_r[IDX_W-1:0];
              head_nxt = slot_lnk;
              if (head_null) begin
                tail_nxt = slot_lnk;
              end
            end
            CMD_INS_END: begin
              fwd_we   = (tail_r != NIL_LINK);
              fwd_wa   = tail_r[IDX_W-1:0];
              tail_nxt = slot_lnk;
              if (tail_r == NIL_LINK) begin
                head_nxt = slot_lnk;
              end
            end
            CMD_INS_AFTER: begin
              fwd_we = 1'b1;
              fwd_wa = at_r[IDX_W-1:0];
              bwd_we = (nf_r != NIL_LINK);
              bwd_wa = nf_r[IDX_W-1:0];
              if (nf_r == NIL_LINK) begin
                tail_nxt = slot_lnk;
              end
            end
            default: begin
              fwd_we = (nb_r != NIL_LINK);
              fwd_wa = nb_r[IDX_W-1:0];
              bwd_we = 1'b1;
              bwd_wa = at_r[IDX_W-1:0];
              if (nb_r == NIL_LINK) begin
                head_nxt = slot_lnk;
              end
            end
          endcase
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase

    out_valid_nxt            = fin;
    out_data_nxt.status      = fin_status;
    out_data_nxt.position    = fit_field(fin_pos);
    out_data_nxt.node_total  = fit_field(len_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL_LINK;
      tail_r      <= NIL_LINK;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    at_r       <= at_nxt;
    nb_r       <= nb_nxt;
    nf_r       <= nf_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/dlle_ram.sv =====
// ----------------------------------------------------------------------------
// dlle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dlle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dlle_alloc.sv =====
// ----------------------------------------------------------------------------
// dlle_alloc
// Slot occupancy flags and lowest-free-slot finder for the node pool.
// ----------------------------------------------------------------------------
module dlle_alloc (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dlle_pkg::alloc_ctl_t    ctl,
  output logic [dlle_pkg::IDX_W-1:0] free_idx
);
  import dlle_pkg::*;

  logic [NODE_COUNT-1:0] in_use_r;
  logic [NODE_COUNT-1:0] in_use_nxt;

  always_comb begin
    in_use_nxt = in_use_r;
    if (ctl.set_en) begin
      in_use_nxt[ctl.idx] = 1'b1;
    end
    if (ctl.clr_en) begin
      in_use_nxt[ctl.idx] = 1'b0;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else begin
      in_use_r <= in_use_nxt;
    end
  end

endmodule

// ===== test/tb_doubly_linked_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_engine_core
// Self-checking testbench of the doubly linked list engine.
// ----------------------------------------------------------------------------
// A list model kept in a queue predicts status, position and node total for
// every command transfer. The expected results are queued, and a monitor
// compares each result strobe with the oldest entry. Directed tests cover the
// empty list, the value extremes, duplicates, head and tail edits, unknown
// commands and the full pool. Random bursts then alternately grow and shrink
// the list under three sender idle rates.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dlle_pkg::*;

  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  logic signed [31:0] list_vals[$];
  out_item_t          list_results[$];
  int                 error_count = 0;
  int                 idle_pct = 0;

  doubly_linked_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("doubly_linked_list_engine_core verification failed");
    $finish;
  end

  function automatic int find_first(logic signed [31:0] v);
    foreach (list_vals[i]) begin
      if (list_vals[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t apply_list_cmd(in_item_t it);
    out_item_t r;
    int at;
    r = '0;
    case (it.command)
      CMD_INS_FRONT, CMD_INS_END: begin
        if (list_vals.size() >= NODE_COUNT) r.status = STAT_FULL;
        else if (it.command == CMD_INS_FRONT) list_vals.push_front(it.item_value);
        else list_vals.push_back(it.item_value);
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        at = find_first(it.anchor_value);
        if (at < 0) r.status = STAT_MISSING;
        else if (list_vals.size() >= NODE_COUNT) r.status = STAT_FULL;
        else if (it.command == CMD_INS_AFTER) list_vals.insert(at + 1, it.item_value);
        else list_vals.insert(at, it.item_value);
      end
      CMD_DELETE: begin
        at = find_first(it.item_value);
        if (at < 0) r.status = STAT_MISSING;
        else list_vals.delete(at);
      end
      CMD_SEARCH: begin
        at = find_first(it.item_value);
        if (at < 0) r.status = STAT_MISSING;
        else r.position = 6'(at + 1);
      end
      default: ;
    endcase
    r.node_total = 6'(list_vals.size());
    return r;
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] v,
                          input logic [31:0] anc);
    in_item_t it;
    it.command      = cmd;
    it.item_value   = v;
    it.anchor_value = anc;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    list_results.push_back(apply_list_cmd(it));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (list_results.size() != 0);
  endtask

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    error_count++;
    if (error_count <= 10)
      $display("%t %s: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/position/total)",
               $realtime, what, want.status, want.position, want.node_total,
               got.status, got.position, got.node_total);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (list_results.size() == 0) begin
        report_mismatch("result with no command pending", '0, out_data);
      end else begin
        want = list_results.pop_front();
        if (out_data.status !== want.status || out_data.position !== want.position ||
            out_data.node_total !== want.node_total)
          report_mismatch("result mismatch", want, out_data);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (list_vals.size() != 0 && r < 55) return list_vals[$urandom_range(list_vals.size() - 1)];
    if (r < 78) return 32'($urandom_range(15)) - 32'd8;
    return $urandom();
  endfunction

  function automatic logic [31:0] absent_value();
    logic [31:0] v;
    do v = $urandom(); while (find_first(v) >= 0);
    return v;
  endfunction

  task automatic test_empty_list();
    send_cmd(CMD_SEARCH, 32'd0, 32'd0);
    send_cmd(CMD_DELETE, 32'hffff_ffff, 32'd0);
    send_cmd(CMD_INS_AFTER, 32'd1, 32'd0);
    send_cmd(CMD_INS_BEFORE, 32'd2, 32'h8000_0000);
    send_cmd(CMD_RSVD_A, 32'd3, 32'd3);
    send_cmd(CMD_RSVD_B, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  task automatic test_edits_and_duplicates();
    send_cmd(CMD_INS_FRONT, 32'h8000_0000, 32'hffff_ffff);
    send_cmd(CMD_INS_END, 32'h7fff_ffff, 32'h0000_0000);
    send_cmd(CMD_INS_AFTER, 32'd0, 32'h8000_0000);
    send_cmd(CMD_INS_BEFORE, 32'hffff_ffff, 32'h8000_0000);
    send_cmd(CMD_INS_AFTER, 32'd5, 32'h7fff_ffff);
    send_cmd(CMD_INS_END, 32'd0, 32'd9);
    send_cmd(CMD_SEARCH, 32'd0, 32'd0);
    send_cmd(CMD_SEARCH, 32'd5, 32'd0);
    send_cmd(CMD_INS_BEFORE, 32'd7, 32'd0);
    send_cmd(CMD_INS_AFTER, 32'd8, 32'd1234);
    send_cmd(CMD_DELETE, 32'hffff_ffff, 32'd0);
    send_cmd(CMD_DELETE, 32'd5, 32'd0);
    send_cmd(CMD_DELETE, 32'd0, 32'd0);
    send_cmd(CMD_SEARCH, 32'd0, 32'd0);
    send_cmd(CMD_DELETE, 32'd42, 32'd0);
    drain_results();
  endtask

  task automatic test_pool_full();
    int k;
    while (list_vals.size() != 0) send_cmd(CMD_DELETE, list_vals[0], $urandom());
    while (list_vals.size() < NODE_COUNT) begin
      k = $urandom_range(3);
      if (list_vals.size() == 0) k = k & 1;
      send_cmd(3'(k), pick_value(),
               (list_vals.size() != 0) ? list_vals[$urandom_range(list_vals.size() - 1)]
                                       : $urandom());
    end
    send_cmd(CMD_INS_FRONT, $urandom(), $urandom());
    send_cmd(CMD_INS_END, $urandom(), $urandom());
    send_cmd(CMD_INS_AFTER, $urandom(), list_vals[0]);
    send_cmd(CMD_INS_BEFORE, $urandom(), list_vals[NODE_COUNT - 1]);
    send_cmd(CMD_INS_AFTER, $urandom(), absent_value());
    send_cmd(CMD_INS_BEFORE, $urandom(), absent_value());
    send_cmd(CMD_SEARCH, list_vals[NODE_COUNT - 1], $urandom());
    send_cmd(CMD_SEARCH, absent_value(), $urandom());
    send_cmd(CMD_RSVD_A, $urandom(), $urandom());
    send_cmd(CMD_DELETE, list_vals[NODE_COUNT - 1], $urandom());
    send_cmd(CMD_INS_BEFORE, $urandom(), list_vals[0]);
  endtask

  task automatic random_burst(int n, bit grow);
    int k;
    logic [2:0] cmd;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 3) cmd = $urandom_range(1) ? CMD_RSVD_A : CMD_RSVD_B;
      else if (k < (grow ? 70 : 25)) cmd = 3'($urandom_range(3));
      else if (k < (grow ? 82 : 80)) cmd = CMD_DELETE;
      else cmd = CMD_SEARCH;
      send_cmd(cmd, pick_value(), pick_value());
    end
  endtask

  task automatic test_random(int pct);
    idle_pct = pct;
    repeat (2) begin
      random_burst(32, 1'b1);
      random_burst(24, 1'b0);
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 25;
    test_empty_list();
    test_edits_and_duplicates();
    test_pool_full();
    test_random(25);
    test_random(67);
    test_random(0);
    drain_results();
    repeat (NODE_COUNT + 8) @(posedge clk);
    if (error_count == 0 && list_results.size() == 0)
      $display("doubly_linked_list_engine_core verification clean");
    else
      $display("doubly_linked_list_engine_core verification failed");
    $finish;
  end

endmodule
